// ----- rtl/cfwl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfwl_pkg
// Shared constants for the circular FIFO with listing: word width, default
// depth, operation codes and result status codes.
// ----------------------------------------------------------------------------
package cfwl_pkg;

    localparam int WORD_W        = 32;
    localparam int DEPTH_DEFAULT = 8;

    localparam logic [1:0] FN_INSERT = 2'd0;
    localparam logic [1:0] FN_REMOVE = 2'd1;
    localparam logic [1:0] FN_LIST   = 2'd2;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_OVERFLOW  = 3'd1;
    localparam logic [2:0] ST_REMOVED   = 3'd2;
    localparam logic [2:0] ST_UNDERFLOW = 3'd3;
    localparam logic [2:0] ST_LISTED    = 3'd4;
    localparam logic [2:0] ST_EMPTY     = 3'd5;

endpackage

`default_nettype wire

// ----- rtl/cfwl_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfwl_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module cfwl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/circular_fifo_with_listing.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// circular_fifo_with_listing
// Circular FIFO of signed words held in one synchronous RAM, with insert,
// remove and list operations.
// ----------------------------------------------------------------------------
// Usage:
//   An item (func, value) is taken on a rising edge with start high and busy
//   low. Each result appears on status/data/last for one cycle with strobe
//   high; the receiver cannot stall, so results are never held back.
//   Insert, overflow, underflow, list-of-empty: result in the cycle after the
//   item is taken, busy stays low, so one item per cycle.
//   Remove: the result passes the registered storage RAM read and then the
//   output registers; busy high for one cycle, no new item taken while busy.
//   List of N entries: the RAM is walked one entry a cycle, with one result
//   per entry through the RAM read and output registers; busy stays high
//   for the walk and no new item is taken while busy. last marks the final
//   result of every item. func 3 gives no result and changes nothing.
//   Reset (rst_n low, asynchronous) empties the queue and returns both
//   pointers to zero; the RAM contents are not cleared.
// ----------------------------------------------------------------------------
module circular_fifo_with_listing #(
    parameter int DEPTH = cfwl_pkg::DEPTH_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [1:0]                        func,
    input  wire logic signed [cfwl_pkg::WORD_W-1:0] value,
    output logic                                   strobe,
    output logic      [2:0]                        status,
    output logic signed [cfwl_pkg::WORD_W-1:0]     data,
    output logic                                   last
);

    localparam int PW = $clog2(DEPTH);
    localparam int WW = cfwl_pkg::WORD_W;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_REMOVE = 2'd1;
    localparam logic [1:0] S_LIST   = 2'd2;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        r = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    logic [1:0]    state_reg, state_next;
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic          empty_reg, empty_next;
    logic [PW-1:0] lp_reg, lp_next;
    logic [PW-1:0] cnt_reg, cnt_next;

    logic          strobe_reg, strobe_next;
    logic [2:0]    status_reg, status_next;
    logic [WW-1:0] data_reg, data_next;
    logic          last_reg, last_next;

    logic          accept;
    logic          full;
    logic          list_fin;
    logic          ram_we;
    logic [PW-1:0] ram_waddr;
    logic [PW-1:0] ram_raddr;
    logic [WW-1:0] ram_rdata;

    assign accept   = start && (state_reg == S_IDLE);
    assign full     = !empty_reg && (wrap_inc(tail_reg) == head_reg);
    assign list_fin = (lp_reg == tail_reg) || (cnt_reg == PW'(DEPTH - 1));

    assign ram_raddr = (state_reg == S_LIST) ? wrap_inc(lp_reg) : head_reg;

    cfwl_ram #(
        .WIDTH (WW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        empty_next  = empty_reg;
        lp_next     = lp_reg;
        cnt_next    = cnt_reg;
        strobe_next = 1'b0;
        status_next = status_reg;
        data_next   = '0;
        last_next   = 1'b1;
        ram_we      = 1'b0;
        ram_waddr   = empty_reg ? '0 : wrap_inc(tail_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (func)
                        cfwl_pkg::FN_INSERT:
                        begin
                            strobe_next = 1'b1;
                            if (full)
                            begin
                                status_next = cfwl_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                status_next = cfwl_pkg::ST_INSERTED;
                                ram_we      = 1'b1;
                                tail_next   = ram_waddr;
                                if (empty_reg)
                                begin
                                    head_next = '0;
                                end
                                empty_next  = 1'b0;
                            end
                        end
                        cfwl_pkg::FN_REMOVE:
                        begin
                            if (empty_reg)
                            begin
                                strobe_next = 1'b1;
                                status_next = cfwl_pkg::ST_UNDERFLOW;
                            end
                            else
                            begin
                                state_next = S_REMOVE;
                                if (head_reg == tail_reg)
                                begin
                                    empty_next = 1'b1;
                                    head_next  = '0;
                                    tail_next  = '0;
                                end
                                else
                                begin
                                    head_next = wrap_inc(head_reg);
                                end
                            end
                        end
                        cfwl_pkg::FN_LIST:
                        begin
                            if (empty_reg)
                            begin
                                strobe_next = 1'b1;
                                status_next = cfwl_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_LIST;
                                lp_next    = head_reg;
                                cnt_next   = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_REMOVE:
            begin
                strobe_next = 1'b1;
                status_next = cfwl_pkg::ST_REMOVED;
                data_next   = ram_rdata;
                state_next  = S_IDLE;
            end
            S_LIST:
            begin
                strobe_next = 1'b1;
                status_next = cfwl_pkg::ST_LISTED;
                data_next   = ram_rdata;
                last_next   = list_fin;
                if (list_fin)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    lp_next  = wrap_inc(lp_reg);
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            empty_reg  <= 1'b1;
            lp_reg     <= '0;
            cnt_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            empty_reg  <= empty_next;
            lp_reg     <= lp_next;
            cnt_reg    <= cnt_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        data_reg   <= data_next;
        last_reg   <= last_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign status = status_reg;
    assign data   = data_reg;
    assign last   = last_reg;

    // Assertions
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        empty_reg |-> (head_reg == '0) && (tail_reg == '0))
        else $error("empty queue with non-zero pointers");

    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (func == cfwl_pkg::FN_INSERT) && full)
        |=> strobe && (status == cfwl_pkg::ST_OVERFLOW) && $stable(tail_reg))
        else $error("insert on full queue not reported as overflow");

    a_remove_res: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REMOVE) |=> strobe && (status == cfwl_pkg::ST_REMOVED) && last)
        else $error("remove gave no removed result");

    a_list_res: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIST) |=> strobe && (status == cfwl_pkg::ST_LISTED))
        else $error("list cycle gave no listed result");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |-> !busy)
        else $error("block still busy after final result");

endmodule

`default_nettype wire
